// ===== rtl/sobel_edge_magnitude_top_macros.svh =====
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define SEM_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define SEM_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sem_pkg.sv =====
// shared constants, types and kernels of the sobel edge magnitude block
package sem_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CH_W      = 8;
   localparam int PIX_W     = 3 * CH_W;
   localparam int GRAD_W    = 11;
   localparam int ACC_W     = 12;
   localparam int SQ_W      = 20;
   localparam int SUM_W     = 21;
   localparam int RAD_W     = 16;
   localparam int ROOT_ITER = RAD_W / 2;
   localparam int ITER_W    = $clog2(ROOT_ITER);
   localparam int REM_W     = 10;
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(65280);
   localparam logic [CH_W-1:0]  MAG_MAX   = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

   typedef logic signed [2:0] coef_type;

   // row-major 3x3 kernels
   localparam coef_type KERN_X [9] = '{-3'sd1, 3'sd0, 3'sd1,
                                       -3'sd2, 3'sd0, 3'sd2,
                                       -3'sd1, 3'sd0, 3'sd1};
   localparam coef_type KERN_Y [9] = '{-3'sd1, -3'sd2, -3'sd1,
                                       3'sd0, 3'sd0, 3'sd0,
                                       3'sd1, 3'sd2, 3'sd1};

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [8:0][PIX_W-1:0] win_type;

   typedef struct packed {
      win_type win;
      logic    last;
      logic    fend;
   } job_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } q_stat_type;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     data;
   } csr_wr_type;

endpackage

// ===== rtl/sem_front.sv =====
// front end: config registers, line stores, window and job classification
module sem_front (
   input  logic                clock,
   input  logic                reset,
   input  sem_pkg::csr_wr_type csr_wr,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [7:0]          req_red_in,
   input  logic [7:0]          req_green_in,
   input  logic [7:0]          req_blue_in,
   output logic                q_push,
   output sem_pkg::job_type    q_data,
   input  sem_pkg::q_stat_type q_stat
);
   import sem_pkg::*;

   typedef enum logic [2:0] {F_IDLE, F_PIX, F_DR0, F_DR1, F_DR2, F_PUSH} fstate_type;

   fstate_type         state_ff, state_in;
   logic [CFG_W-1:0]   width_cfg_ff, width_cfg_in;
   logic [CFG_W-1:0]   height_cfg_ff, height_cfg_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [WCNT_W-1:0]  drain_ff, drain_in;
   win_type            win_ff, win_in;
   pix_type            pix_ff, pix_in;
   job_type            pend_ff [2];
   job_type            pend_in [2];
   logic [1:0]         pend_cnt_ff, pend_cnt_in;
   logic               pend_sel_ff, pend_sel_in;
   pix_type            dup_ff [2];
   pix_type            dup_in [2];
   pix_type            dmid_ff [2];
   pix_type            dmid_in [2];

   pix_type            upper_mem [MAX_WIDTH];
   pix_type            middle_mem [MAX_WIDTH];
   pix_type            up_q, mid_q;
   logic [COL_W-1:0]   rd_addr;

   logic [WCNT_W-1:0]  w_eff;
   logic [ROW_W-1:0]   h_eff;
   logic               h_ge2;
   pix_type            up_m, mid_m;
   logic [WCNT_W-1:0]  col_p1, drain_p1;
   logic               row_end, col_zero;
   win_type            new_win, end_win, drain_win;
   logic               ok0, ok2, drain_fend;

   // out-of-range sizes clamp to one or to the maximum
   always_comb begin
      if (width_cfg_ff == '0) begin
         w_eff = WCNT_W'(1);
      end else if (int'(width_cfg_ff) > MAX_WIDTH) begin
         w_eff = WCNT_W'(MAX_WIDTH);
      end else begin
         w_eff = WCNT_W'(width_cfg_ff);
      end
      if (height_cfg_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (int'(height_cfg_ff) > MAX_HEIGHT) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(height_cfg_ff);
      end
   end

   assign h_ge2 = h_eff >= ROW_W'(2);

   always_comb begin
      case (state_ff)
         F_IDLE:  rd_addr = req_command ? COL_W'(drain_ff - WCNT_W'(1)) : col_ff;
         F_DR0:   rd_addr = COL_W'(drain_ff);
         F_DR1:   rd_addr = COL_W'(drain_ff + WCNT_W'(1));
         default: rd_addr = col_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_PIX) begin
         upper_mem[col_ff]  <= mid_m;
         middle_mem[col_ff] <= pix_ff;
      end
      up_q  <= upper_mem[rd_addr];
      mid_q <= middle_mem[rd_addr];
   end

   // pixel path: masked taps, shifted window, row-end window
   always_comb begin
      up_m     = (row_ff >= ROW_W'(2)) ? up_q : '0;
      mid_m    = (row_ff >= ROW_W'(1)) ? mid_q : '0;
      col_p1   = WCNT_W'(col_ff) + WCNT_W'(1);
      row_end  = col_p1 == w_eff;
      col_zero = col_ff == '0;
      for (int i = 0; i < 3; i++) begin
         new_win[3*i]     = col_zero ? '0 : win_ff[3*i+1];
         new_win[3*i+1]   = col_zero ? '0 : win_ff[3*i+2];
         new_win[3*i+2]   = (i == 0) ? up_m : ((i == 1) ? mid_m : pix_ff);
      end
      for (int i = 0; i < 3; i++) begin
         end_win[3*i]   = new_win[3*i+1];
         end_win[3*i+1] = new_win[3*i+2];
         end_win[3*i+2] = '0;
      end
   end

   // drain path: last two rows, bottom row outside the frame
   always_comb begin
      drain_p1   = drain_ff + WCNT_W'(1);
      ok0        = drain_ff != '0;
      ok2        = drain_p1 < w_eff;
      drain_fend = drain_p1 == w_eff;
      drain_win[0] = dup_ff[0];
      drain_win[1] = dup_ff[1];
      drain_win[2] = (ok2 && h_ge2) ? up_q : '0;
      drain_win[3] = dmid_ff[0];
      drain_win[4] = dmid_ff[1];
      drain_win[5] = ok2 ? mid_q : '0;
      drain_win[6] = '0;
      drain_win[7] = '0;
      drain_win[8] = '0;
   end

   assign req_ready = state_ff == F_IDLE;
   assign q_push    = (state_ff == F_PUSH) && (pend_cnt_ff != 2'd0) && !q_stat.full;
   assign q_data    = pend_ff[pend_sel_ff];

   always_comb begin
      state_in      = state_ff;
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      drain_in      = drain_ff;
      win_in        = win_ff;
      pix_in        = pix_ff;
      pend_in       = pend_ff;
      pend_cnt_in   = pend_cnt_ff;
      pend_sel_in   = pend_sel_ff;
      dup_in        = dup_ff;
      dmid_in       = dmid_ff;

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               if (!req_command) begin
                  if (row_ff < h_eff) begin
                     pix_in   = {req_red_in, req_green_in, req_blue_in};
                     state_in = F_PIX;
                  end
               end else if (!(row_ff < h_eff) && (drain_ff < w_eff)) begin
                  state_in = F_DR0;
               end
            end
         end
         F_PIX: begin
            win_in      = new_win;
            pend_sel_in = 1'b0;
            pend_cnt_in = 2'd0;
            if (row_ff >= ROW_W'(1)) begin
               if (!col_zero && row_end) begin
                  pend_in[0]  = '{win: new_win, last: 1'b0, fend: 1'b0};
                  pend_in[1]  = '{win: end_win, last: 1'b1, fend: 1'b0};
                  pend_cnt_in = 2'd2;
               end else if (!col_zero) begin
                  pend_in[0]  = '{win: new_win, last: 1'b1, fend: 1'b0};
                  pend_cnt_in = 2'd1;
               end else if (row_end) begin
                  pend_in[0]  = '{win: end_win, last: 1'b1, fend: 1'b0};
                  pend_cnt_in = 2'd1;
               end
            end
            if (col_p1 >= w_eff) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = COL_W'(col_p1);
            end
            if ((row_ff >= ROW_W'(1)) && (!col_zero || row_end)) begin
               state_in = F_PUSH;
            end else begin
               state_in = F_IDLE;
            end
         end
         F_DR0: begin
            dup_in[0]  = (ok0 && h_ge2) ? up_q : '0;
            dmid_in[0] = ok0 ? mid_q : '0;
            state_in   = F_DR1;
         end
         F_DR1: begin
            dup_in[1]  = h_ge2 ? up_q : '0;
            dmid_in[1] = mid_q;
            state_in   = F_DR2;
         end
         F_DR2: begin
            pend_in[0]  = '{win: drain_win, last: 1'b1, fend: drain_fend};
            pend_cnt_in = 2'd1;
            pend_sel_in = 1'b0;
            drain_in    = drain_p1;
            if (drain_fend) begin
               row_in   = '0;
               col_in   = '0;
               drain_in = '0;
               win_in   = '0;
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (q_push) begin
               pend_cnt_in = pend_cnt_ff - 2'd1;
               pend_sel_in = 1'b1;
               if (pend_cnt_ff == 2'd1) begin
                  state_in = F_IDLE;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase

      // a width or height register write restarts the frame
      if (csr_wr.valid && ((csr_wr.index == CSR_FRAME_WIDTH) ||
                           (csr_wr.index == CSR_FRAME_HEIGHT))) begin
         if (csr_wr.index == CSR_FRAME_WIDTH) begin
            width_cfg_in = csr_wr.data;
         end else begin
            height_cfg_in = csr_wr.data;
         end
         row_in   = '0;
         col_in   = '0;
         drain_in = '0;
         win_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         width_cfg_ff  <= WIDTH_RESET;
         height_cfg_ff <= HEIGHT_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         drain_ff      <= '0;
         win_ff        <= '0;
         pend_cnt_ff   <= 2'd0;
         pend_sel_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         drain_ff      <= drain_in;
         win_ff        <= win_in;
         pend_cnt_ff   <= pend_cnt_in;
         pend_sel_ff   <= pend_sel_in;
      end
      pix_ff  <= pix_in;
      pend_ff <= pend_in;
      dup_ff  <= dup_in;
      dmid_ff <= dmid_in;
   end

endmodule

// ===== rtl/sem_queue.sv =====
// short job queue between front and back
module sem_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sem_pkg::job_type     push_data,
   input  logic                 pop,
   output sem_pkg::job_type     head,
   output sem_pkg::q_stat_type  stat
);
   import sem_pkg::*;

   job_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full  = count_ff == QCNT_W'(QDEPTH);
   assign stat.empty = count_ff == '0;
   assign stat.count = count_ff;
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QDEPTH - 1) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QDEPTH - 1) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sem_back.sv =====
// back end: gradients, squares, bit-serial rounded square root, result register
module sem_back (
   input  logic                clock,
   input  logic                reset,
   input  sem_pkg::job_type    q_head,
   input  sem_pkg::q_stat_type q_stat,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_red_out,
   output logic [7:0]          rsp_green_out,
   output logic [7:0]          rsp_blue_out,
   output logic                rsp_last_of_run,
   output logic                rsp_frame_end
);
   import sem_pkg::*;

   typedef enum logic [2:0] {B_IDLE, B_SQ, B_SUM, B_ROOT, B_DONE} bstate_type;

   bstate_type               state_ff, state_in;
   logic signed [GRAD_W-1:0] gx_ff [3];
   logic signed [GRAD_W-1:0] gx_in [3];
   logic signed [GRAD_W-1:0] gy_ff [3];
   logic signed [GRAD_W-1:0] gy_in [3];
   logic [SQ_W-1:0]          sqx_ff [3];
   logic [SQ_W-1:0]          sqx_in [3];
   logic [SQ_W-1:0]          sqy_ff [3];
   logic [SQ_W-1:0]          sqy_in [3];
   logic [RAD_W-1:0]         rad_ff [3];
   logic [RAD_W-1:0]         rad_in [3];
   logic [REM_W-1:0]         rem_ff [3];
   logic [REM_W-1:0]         rem_in [3];
   logic [CH_W-1:0]          root_ff [3];
   logic [CH_W-1:0]          root_in [3];
   logic [2:0]               sat_ff, sat_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     last_ff, last_in;
   logic                     fend_ff, fend_in;
   logic                     valid_ff, valid_in;
   logic [CH_W-1:0]          out_ff [3];
   logic [CH_W-1:0]          out_in [3];
   logic                     olast_ff, olast_in;
   logic                     ofend_ff, ofend_in;

   logic signed [ACC_W-1:0]  acc_x [3];
   logic signed [ACC_W-1:0]  acc_y [3];
   logic [SUM_W-1:0]         sum_s [3];
   logic [REM_W+1:0]         rem_sh [3];
   logic [REM_W+1:0]         trial [3];
   logic [CH_W-1:0]          mag [3];
   logic                     out_free;

   assign out_free = !valid_ff || rsp_ready;
   assign q_pop    = (state_ff == B_IDLE) && !q_stat.empty;

   // 3x3 correlation with both kernels for each color channel
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         acc_x[ch] = '0;
         acc_y[ch] = '0;
         for (int k = 0; k < 9; k++) begin
            acc_x[ch] = acc_x[ch] + ACC_W'(signed'({4'b0, q_head.win[k][16-8*ch +: 8]})
                                          * KERN_X[k]);
            acc_y[ch] = acc_y[ch] + ACC_W'(signed'({4'b0, q_head.win[k][16-8*ch +: 8]})
                                          * KERN_Y[k]);
         end
         sum_s[ch]  = SUM_W'(sqx_ff[ch]) + SUM_W'(sqy_ff[ch]);
         rem_sh[ch] = {rem_ff[ch], rad_ff[ch][RAD_W-1 -: 2]};
         trial[ch]  = (REM_W+2)'({root_ff[ch], 2'b01});
         // round half up from the exact remainder
         if (sat_ff[ch]) begin
            mag[ch] = MAG_MAX;
         end else if (REM_W'(root_ff[ch]) < rem_ff[ch]) begin
            mag[ch] = root_ff[ch] + CH_W'(1);
         end else begin
            mag[ch] = root_ff[ch];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      sat_in   = sat_ff;
      iter_in  = iter_ff;
      last_in  = last_ff;
      fend_in  = fend_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      olast_in = olast_ff;
      ofend_in = ofend_ff;

      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end

      case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               for (int ch = 0; ch < 3; ch++) begin
                  gx_in[ch] = GRAD_W'(acc_x[ch]);
                  gy_in[ch] = GRAD_W'(acc_y[ch]);
               end
               last_in  = q_head.last;
               fend_in  = q_head.fend;
               state_in = B_SQ;
            end
         end
         B_SQ: begin
            for (int ch = 0; ch < 3; ch++) begin
               sqx_in[ch] = SQ_W'(gx_ff[ch] * gx_ff[ch]);
               sqy_in[ch] = SQ_W'(gy_ff[ch] * gy_ff[ch]);
            end
            state_in = B_SUM;
         end
         B_SUM: begin
            for (int ch = 0; ch < 3; ch++) begin
               sat_in[ch]  = sum_s[ch] > SAT_LIMIT;
               rad_in[ch]  = RAD_W'(sum_s[ch]);
               rem_in[ch]  = '0;
               root_in[ch] = '0;
            end
            iter_in  = '0;
            state_in = B_ROOT;
         end
         B_ROOT: begin
            // two radicand bits per step, one root bit out
            for (int ch = 0; ch < 3; ch++) begin
               rad_in[ch] = rad_ff[ch] << 2;
               if (rem_sh[ch] >= trial[ch]) begin
                  rem_in[ch]  = REM_W'(rem_sh[ch] - trial[ch]);
                  root_in[ch] = {root_ff[ch][CH_W-2:0], 1'b1};
               end else begin
                  rem_in[ch]  = REM_W'(rem_sh[ch]);
                  root_in[ch] = {root_ff[ch][CH_W-2:0], 1'b0};
               end
            end
            iter_in = iter_ff + ITER_W'(1);
            if (int'(iter_ff) == ROOT_ITER - 1) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               out_in   = mag;
               olast_in = last_ff;
               ofend_in = fend_ff;
               valid_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         iter_ff  <= iter_in;
      end
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      sat_ff   <= sat_in;
      last_ff  <= last_in;
      fend_ff  <= fend_in;
      out_ff   <= out_in;
      olast_ff <= olast_in;
      ofend_ff <= ofend_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_red_out     = out_ff[0];
   assign rsp_green_out   = out_ff[1];
   assign rsp_blue_out    = out_ff[2];
   assign rsp_last_of_run = olast_ff;
   assign rsp_frame_end   = ofend_ff;

endmodule

// ===== rtl/sobel_edge_magnitude_top.sv =====
// top level of the streaming rgb sobel edge magnitude block
//
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    command, red/green/blue in
// rsp       out        rsp_valid/rsp_ready    red/green/blue out, last_of_run, frame_end
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// a pixel passes the front through the pixel state and one push per result it causes,
// a drain through three line store reads and a push; ignored items stay in idle
// each result passes through the back as gradients, squares, sum, 8 root steps
// a two-entry job queue sits between front and back; the result register holds
// while rsp_ready is low and the front keeps accepting until the queue fills
// reset is synchronous; line stores are not cleared, reads are masked by row
module sobel_edge_magnitude_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [7:0]                    req_red_in,
   input  logic [7:0]                    req_green_in,
   input  logic [7:0]                    req_blue_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_red_out,
   output logic [7:0]                    rsp_green_out,
   output logic [7:0]                    rsp_blue_out,
   output logic                          rsp_last_of_run,
   output logic                          rsp_frame_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sem_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sem_pkg::CFG_W-1:0]     csr_data
);
   import sem_pkg::*;
   `include "sobel_edge_magnitude_top_macros.svh"

   csr_wr_type csr_wr;
   job_type    push_data;
   job_type    q_head;
   q_stat_type q_stat;
   logic       q_push;
   logic       q_pop;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   sem_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr       (csr_wr),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .q_push       (q_push),
      .q_data       (push_data),
      .q_stat       (q_stat)
   );

   sem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   sem_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_stat          (q_stat),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end)
   );

   `SEM_ASSERT_SAME(a_push_not_full, clock, reset, q_push, !q_stat.full, "push into full queue")
   `SEM_ASSERT_SAME(a_pop_not_empty, clock, reset, q_pop, !q_stat.empty, "pop from empty queue")
   `SEM_ASSERT_SAME(a_fend_is_last, clock, reset, rsp_valid && rsp_frame_end, rsp_last_of_run, "frame end without last of run")
   `SEM_ASSERT_NEXT(a_push_counts, clock, reset, q_push && !q_pop && (q_stat.count == '0), q_stat.count == QCNT_W'(1), "queue count lost a push")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the streaming rgb sobel edge magnitude block
`timescale 1ns / 100ps

module tb;
   import sem_pkg::*;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
      logic       fend;
   } edge_result_type;

   typedef struct {
      logic       cmd;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic       typed;
      logic [7:0] er;
      logic [7:0] eg;
      logic [7:0] eb;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = CMD_PIXEL;
   logic [7:0] req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic rsp_last_of_run, rsp_frame_end;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [CFG_W-1:0] csr_data = '0;

   sobel_edge_magnitude_top dut (.*);

   always #1 clock = ~clock;

   // predictor state
   int unsigned width_reg, height_reg;
   logic [23:0] upper_row [MAX_WIDTH];
   logic [23:0] middle_row [MAX_WIDTH];
   logic [23:0] win [3][3];
   int unsigned row_cnt, col_cnt, drain_cnt;

   edge_result_type pending_results[$];
   int errors = 0;
   bit quiet = 0;       // no idling in the final stretch
   bit long_stall = 0;

   function automatic int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      return v > MAX_WIDTH ? MAX_WIDTH : v;
   endfunction

   function automatic logic [7:0] round_magnitude(int gx, int gy);
      int unsigned s, q;
      s = gx * gx + gy * gy;
      if (s > 65280) return 8'd255;
      q = 0;
      while ((q + 1) * (q + 1) <= s) q++;
      if (s - q * q > q) q++;
      return q[7:0];
   endfunction

   function automatic edge_result_type sobel_of(logic [23:0] w [3][3], logic last,
                                                logic fend);
      edge_result_type res;
      logic [7:0] mag [3];
      int gx, gy, p;
      for (int ch = 0; ch < 3; ch++) begin
         gx = 0;
         gy = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               p = (w[i][j] >> (16 - 8 * ch)) & 8'hff;
               gx += p * KERN_X[i*3+j];
               gy += p * KERN_Y[i*3+j];
            end
         mag[ch] = round_magnitude(gx, gy);
      end
      res.red = mag[0];
      res.green = mag[1];
      res.blue = mag[2];
      res.last = last;
      res.fend = fend;
      return res;
   endfunction

   function automatic void restart_frame();
      row_cnt = 0;
      col_cnt = 0;
      drain_cnt = 0;
      foreach (win[i, j]) win[i][j] = '0;
   endfunction

   // returns number of results predicted
   function automatic int predict_edges(logic cmd, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b);
      int unsigned w, h, col, c;
      logic [23:0] t [3][3];
      logic [23:0] pix, up, mid;
      bit ok, row_end, fend;
      int n;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      n = 0;
      if (cmd == CMD_DRAIN) begin
         if (row_cnt < h || drain_cnt >= w) return 0;
         for (int j = 0; j < 3; j++) begin
            col = drain_cnt + j;
            ok = col >= 1 && col - 1 < w;
            c = ok ? col - 1 : 0;
            t[0][j] = (ok && h >= 2) ? upper_row[c] : '0;
            t[1][j] = ok ? middle_row[c] : '0;
            t[2][j] = '0;
         end
         fend = (drain_cnt + 1 == w);
         pending_results.push_back(sobel_of(t, 1'b1, fend));
         drain_cnt++;
         if (fend) restart_frame();
         return 1;
      end
      if (row_cnt >= h) return 0;
      pix = {r, g, b};
      up = row_cnt >= 2 ? upper_row[col_cnt] : '0;
      mid = row_cnt >= 1 ? middle_row[col_cnt] : '0;
      upper_row[col_cnt] = mid;
      middle_row[col_cnt] = pix;
      if (col_cnt == 0) foreach (win[i, j]) win[i][j] = '0;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = pix;
      if (row_cnt >= 1) begin
         row_end = (col_cnt + 1 == w);
         if (col_cnt >= 1) begin
            pending_results.push_back(sobel_of(win, !row_end, 1'b0));
            n++;
         end
         if (row_end) begin
            for (int i = 0; i < 3; i++) begin
               t[i][0] = win[i][1];
               t[i][1] = win[i][2];
               t[i][2] = '0;
            end
            pending_results.push_back(sobel_of(t, 1'b1, 1'b0));
            n++;
         end
      end
      col_cnt++;
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt++;
      end
      return n;
   endfunction

   // valid drops only for a gap, so back to back items keep it high
   task automatic idle_gap();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      idle_gap();
      req_valid <= 1'b1;
      req_command <= cmd;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      void'(predict_edges(cmd, r, g, b));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      restart_frame();
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_frame(int unsigned w, int unsigned h, int pixels);
      int unsigned k;
      write_csr(CSR_FRAME_WIDTH, w[CFG_W-1:0]);
      write_csr(CSR_FRAME_HEIGHT, h[CFG_W-1:0]);
      for (int i = 0; i < pixels; i++) begin
         k = $urandom_range(0, 19);
         send_item(k == 0 ? CMD_DRAIN : CMD_PIXEL,
                   k < 3 ? 8'hff : 8'($urandom), 8'($urandom),
                   k == 4 ? 8'h00 : 8'($urandom));
      end
      for (int i = 0; i < clamp_dim(w) + 1; i++)
         send_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      wait_drained();
   endtask

   // result checker
   always @(posedge clock) begin
      edge_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_red_out !== exp_r.red) begin
               $error("red_out expected %0d actual %0d", exp_r.red, rsp_red_out);
               errors++;
            end
            if (rsp_green_out !== exp_r.green) begin
               $error("green_out expected %0d actual %0d", exp_r.green, rsp_green_out);
               errors++;
            end
            if (rsp_blue_out !== exp_r.blue) begin
               $error("blue_out expected %0d actual %0d", exp_r.blue, rsp_blue_out);
               errors++;
            end
            if (rsp_last_of_run !== exp_r.last) begin
               $error("last_of_run expected %0d actual %0d", exp_r.last, rsp_last_of_run);
               errors++;
            end
            if (rsp_frame_end !== exp_r.fend) begin
               $error("frame_end expected %0d actual %0d", exp_r.fend, rsp_frame_end);
               errors++;
            end
         end
      end
   end

   // receiver with random stalls and one long hold-off
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_stall) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            long_stall = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      logic [7:0] v;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (upper_row[i]) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      restart_frame();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // drain with nothing pending after reset gives nothing
      send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
      wait_drained();

      // single pixel frame: width and height as small as allowed, zero acts as one
      write_csr(CSR_FRAME_WIDTH, 11'd0);
      write_csr(CSR_FRAME_HEIGHT, 11'd1);
      // a lone pixel gives zero gradient; typed rows check that directly
      rows = '{
         '{CMD_PIXEL, 8'hff, 8'h00, 8'h80, 1'b0, 8'd0, 8'd0, 8'd0},
         '{CMD_PIXEL, 8'h12, 8'h34, 8'h56, 1'b0, 8'd0, 8'd0, 8'd0},
         '{CMD_DRAIN, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0, 8'd0, 8'd0},
         '{CMD_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_item(row.cmd, row.r, row.g, row.b);
         if (row.typed && pending_results.size() != 0) begin
            v = pending_results[$].red;
            if (v !== row.er || pending_results[$].green !== row.eg ||
                pending_results[$].blue !== row.eb) begin
               $error("typed row %0d expected %0d actual %0d", i, row.er, v);
               errors++;
            end
         end
      end
      wait_drained();

      // 3x3 frame with extreme checkerboard, saturating magnitudes
      write_csr(CSR_FRAME_WIDTH, 11'd3);
      write_csr(CSR_FRAME_HEIGHT, 11'd3);
      for (int i = 0; i < 9; i++)
         send_item(CMD_PIXEL, (i % 2) ? 8'hff : 8'h00, (i % 2) ? 8'h00 : 8'hff, 8'hff);
      send_item(CMD_PIXEL, 8'h55, 8'haa, 8'h01);   // ignored after full frame
      for (int i = 0; i < 4; i++) send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
      wait_drained();

      // width above max clamps, height one: pixels alone give no results, results come only from drains
      write_csr(CSR_FRAME_HEIGHT, 11'd1);
      write_csr(CSR_FRAME_WIDTH, 11'd2047);
      for (int i = 0; i < 4; i++) send_item(CMD_PIXEL, 8'hff, 8'hff, 8'hff);
      wait_drained();
      write_csr(CSR_FRAME_WIDTH, 11'd1);
      write_csr(CSR_FRAME_HEIGHT, 11'd2);
      send_item(CMD_PIXEL, 8'hff, 8'h00, 8'h7f);
      send_item(CMD_PIXEL, 8'h00, 8'hff, 8'h80);
      send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
      wait_drained();

      // random frames; long hold-off in the first one fills the block
      long_stall = 1;
      random_frame(8, 4, 40);
      for (int f = 0; f < 10; f++)
         random_frame($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(10, 60));
      random_frame(24, 1, 30);
      quiet = 1;
      random_frame(5, 5, 30);

      if (errors == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sem_pkg.sv
rtl/sem_front.sv
rtl/sem_queue.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude_top.sv
tb/tb.sv
